FILE: hw/rtl/ilte_pkg.sv
// ----------------------------------------------------------------------------
// ilte_pkg
// Shared types and constants for the indexed list table engine.
// ----------------------------------------------------------------------------
package ilte_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int MODE_W         = 4;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 4'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_FRONT   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_BACK    = 4'd3;
    localparam logic [MODE_W-1:0] MODE_READ_AT = 4'd4;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_ERASE   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_FIND    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_SWAP_V  = 4'd8;
    localparam logic [MODE_W-1:0] MODE_SWAP_I  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 4'd10;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_MISSING = 3'd4
    } t_status;

    typedef struct packed {
        logic    found;
        t_status status;
    } t_flags;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDWAIT,
        S_INS,
        S_INS_PUT,
        S_WALK,
        S_SWV_A,
        S_SWV_B,
        S_SWI_1,
        S_SWI_2,
        S_SWI_3,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/ilte_mem.sv
// ----------------------------------------------------------------------------
// ilte_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ilte_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ilte_out_buf.sv
// ----------------------------------------------------------------------------
// ilte_out_buf
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module ilte_out_buf #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DATA_WIDTH-1:0]  i_data,
    input  ilte_pkg::t_flags       i_flags,
    input  logic [CNT_W-1:0]       i_count,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [DATA_WIDTH-1:0]  o_data,
    output ilte_pkg::t_flags       o_flags,
    output logic [CNT_W-1:0]       o_count
);

    import ilte_pkg::*;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_data;
    t_flags                r_flags;
    logic [CNT_W-1:0]      r_count;

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data  <= i_data;
            r_flags <= i_flags;
            r_count <= i_count;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_flags = r_flags;
    assign o_count = r_count;

endmodule

FILE: hw/rtl/indexed_list_table_engine.sv
// Push, pop, clear, append, unused modes and rejected requests go straight to the result;
// front, back and read at wait for read data; erase, find and swap by value walk the list;
// a shifting insert moves entries down from the tail; swap by index reads both and writes
// them back. The next request is taken the cycle after the result register takes the
// current one; the single read port sets the walk length.
// Reset (synchronous, active low) empties the list and drops a pending result.
// ----------------------------------------------------------------------------
// indexed_list_table_engine
// Ordered list of up to DEPTH values kept in a memory, with a request sequencer.
// ----------------------------------------------------------------------------
module indexed_list_table_engine #(
    parameter int DEPTH      = ilte_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ilte_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ilte_pkg::MODE_W-1:0] i_mode,
    input  logic signed [$clog2(DEPTH):0] i_position,
    input  logic [$clog2(DEPTH)-1:0]    i_other_position,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic signed [DATA_WIDTH-1:0] i_other_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_read_value,
    output logic                        o_found,
    output logic [$clog2(DEPTH+1)-1:0]  o_count,
    output ilte_pkg::t_status           o_status
);

    import ilte_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [MODE_W-1:0]     r_mode, n_mode;
    logic [AW-1:0]         r_pos, n_pos;
    logic [AW-1:0]         r_opos, n_opos;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [DATA_WIDTH-1:0] r_oval, n_oval;
    logic [AW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_kept, n_kept;
    logic                  r_fa, n_fa;
    logic                  r_fb, n_fb;
    logic [AW-1:0]         r_ia, n_ia;
    logic [AW-1:0]         r_ib, n_ib;
    logic [DATA_WIDTH-1:0] r_tmp, n_tmp;
    logic [DATA_WIDTH-1:0] r_res_data, n_res_data;
    t_flags                r_res_flags, n_res_flags;

    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

    logic                  res_valid, res_ready;
    t_flags                out_flags;

    logic                  accept;
    logic                  pos_neg, pos_last, pos_lt_cnt, pos_le_cnt, opos_lt_cnt;
    logic [AW-1:0]         pos_idx, last_idx;
    logic [CW-1:0]         pos_ext, cnt_m1;
    logic                  is_full, is_empty;
    logic                  rdat_ok, ins_ok, ins_append, swi_ok;
    logic                  w_last, w_hit_a, w_hit_b, w_fa, w_fb;
    logic [CW-1:0]         w_kept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign pos_neg     = i_position[AW];
    assign pos_last    = (i_position == '1);
    assign pos_idx     = i_position[AW-1:0];
    assign pos_ext     = CW'(pos_idx);
    assign pos_lt_cnt  = !pos_neg && (pos_ext < r_count);
    assign pos_le_cnt  = !pos_neg && (pos_ext <= r_count);
    assign opos_lt_cnt = (CW'(i_other_position) < r_count);
    assign is_full     = (r_count == CW'(DEPTH));
    assign is_empty    = (r_count == '0);
    assign cnt_m1      = r_count - CW'(1);
    assign last_idx    = cnt_m1[AW-1:0];
    assign rdat_ok     = pos_last ? !is_empty : pos_lt_cnt;
    assign ins_ok      = !is_full && pos_le_cnt;
    assign ins_append  = (pos_ext == r_count);
    assign swi_ok      = pos_lt_cnt && opos_lt_cnt;

    // walk: read data for entry r_idx arrives this cycle
    assign w_last  = (CW'(r_idx) == cnt_m1);
    assign w_hit_a = (mem_rdata == r_val);
    assign w_hit_b = (mem_rdata == r_oval);
    assign w_fa    = r_fa || w_hit_a;
    assign w_fb    = r_fb || w_hit_b;
    assign w_kept  = w_hit_a ? r_kept : r_kept + CW'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DONE;
                    case (i_mode)
                        MODE_FRONT, MODE_BACK: if (!is_empty) n_state = S_RDWAIT;
                        MODE_READ_AT: if (rdat_ok) n_state = S_RDWAIT;
                        MODE_INSERT: if (ins_ok && !ins_append) n_state = S_INS;
                        MODE_ERASE, MODE_FIND, MODE_SWAP_V: if (!is_empty) n_state = S_WALK;
                        MODE_SWAP_I: if (swi_ok) n_state = S_SWI_1;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RDWAIT:  n_state = S_DONE;
            S_INS:     if (r_idx == r_pos) n_state = S_INS_PUT;
            S_INS_PUT: n_state = S_DONE;
            S_WALK: begin
                if (w_last) begin
                    if (r_mode == MODE_SWAP_V && w_fa && w_fb) n_state = S_SWV_A;
                    else n_state = S_DONE;
                end
            end
            S_SWV_A:   n_state = S_SWV_B;
            S_SWV_B:   n_state = S_DONE;
            S_SWI_1:   n_state = S_SWI_2;
            S_SWI_2:   n_state = S_SWI_3;
            S_SWI_3:   n_state = S_DONE;
            S_DONE:    if (res_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_val;
        mem_re      = 1'b0;
        mem_raddr   = r_pos;
        res_valid   = 1'b0;
        n_count     = r_count;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_opos      = r_opos;
        n_val       = r_val;
        n_oval      = r_oval;
        n_idx       = r_idx;
        n_kept      = r_kept;
        n_fa        = r_fa;
        n_fb        = r_fb;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_tmp       = r_tmp;
        n_res_data  = r_res_data;
        n_res_flags = r_res_flags;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode             = i_mode;
                    n_pos              = pos_idx;
                    n_opos             = i_other_position;
                    n_val              = i_value;
                    n_oval             = i_other_value;
                    n_idx              = '0;
                    n_kept             = '0;
                    n_fa               = 1'b0;
                    n_fb               = 1'b0;
                    n_res_data         = '0;
                    n_res_flags.found  = 1'b0;
                    n_res_flags.status = ST_OK;
                    mem_wdata          = i_value;
                    case (i_mode)
                        MODE_PUSH: begin
                            if (is_full) begin
                                n_res_flags.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                n_count   = r_count + CW'(1);
                            end
                        end
                        MODE_POP: begin
                            if (is_empty) n_res_flags.status = ST_EMPTY;
                            else n_count = cnt_m1;
                        end
                        MODE_FRONT, MODE_BACK: begin
                            if (is_empty) begin
                                n_res_flags.status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = (i_mode == MODE_FRONT) ? '0 : last_idx;
                            end
                        end
                        MODE_READ_AT: begin
                            if (!rdat_ok) begin
                                n_res_flags.status = pos_last ? ST_EMPTY : ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = pos_last ? last_idx : pos_idx;
                            end
                        end
                        MODE_INSERT: begin
                            if (is_full) begin
                                n_res_flags.status = ST_FULL;
                            end else if (!pos_le_cnt) begin
                                n_res_flags.status = ST_RANGE;
                            end else if (ins_append) begin
                                mem_we    = 1'b1;
                                mem_waddr = pos_idx;
                                n_count   = r_count + CW'(1);
                            end else begin
                                // shift down from the tail, one entry a cycle
                                mem_re    = 1'b1;
                                mem_raddr = last_idx;
                                n_idx     = last_idx;
                            end
                        end
                        MODE_ERASE, MODE_FIND, MODE_SWAP_V: begin
                            if (is_empty) begin
                                n_res_flags.status = ST_MISSING;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                            end
                        end
                        MODE_SWAP_I: begin
                            if (!swi_ok) begin
                                n_res_flags.status = ST_RANGE;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = pos_idx;
                            end
                        end
                        MODE_CLEAR: n_count = '0;
                        default: n_count = r_count;
                    endcase
                end
            end
            S_RDWAIT: n_res_data = mem_rdata;
            S_INS: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx + AW'(1);
                mem_wdata = mem_rdata;
                if (r_idx != r_pos) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx - AW'(1);
                    n_idx     = r_idx - AW'(1);
                end
            end
            S_INS_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_val;
                n_count   = r_count + CW'(1);
            end
            S_WALK: begin
                n_fa = w_fa;
                n_fb = w_fb;
                if (!r_fa && w_hit_a) n_ia = r_idx;
                if (!r_fb && w_hit_b) n_ib = r_idx;
                if (r_mode == MODE_ERASE) begin
                    // compact survivors; write slot never passes the read slot
                    n_kept = w_kept;
                    if (!w_hit_a) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_kept[AW-1:0];
                        mem_wdata = mem_rdata;
                    end
                end
                if (!w_last) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end else if (r_mode == MODE_SWAP_V) begin
                    n_res_flags.status = (w_fa && w_fb) ? ST_OK : ST_MISSING;
                end else begin
                    n_res_flags.found  = w_fa;
                    n_res_flags.status = w_fa ? ST_OK : ST_MISSING;
                    if (r_mode == MODE_ERASE) n_count = w_kept;
                end
            end
            S_SWV_A: begin
                mem_we    = 1'b1;
                mem_waddr = r_ia;
                mem_wdata = r_oval;
            end
            S_SWV_B: begin
                mem_we    = 1'b1;
                mem_waddr = r_ib;
                mem_wdata = r_val;
            end
            S_SWI_1: begin
                n_tmp     = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = r_opos;
            end
            S_SWI_2: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = mem_rdata;
            end
            S_SWI_3: begin
                mem_we    = 1'b1;
                mem_waddr = r_opos;
                mem_wdata = r_tmp;
            end
            S_DONE: res_valid = 1'b1;
            default: res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_pos       <= n_pos;
        r_opos      <= n_opos;
        r_val       <= n_val;
        r_oval      <= n_oval;
        r_idx       <= n_idx;
        r_kept      <= n_kept;
        r_fa        <= n_fa;
        r_fb        <= n_fb;
        r_ia        <= n_ia;
        r_ib        <= n_ib;
        r_tmp       <= n_tmp;
        r_res_data  <= n_res_data;
        r_res_flags <= n_res_flags;
    end

    ilte_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ilte_out_buf #(
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CW)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_data  (r_res_data),
        .i_flags (r_res_flags),
        .i_count (r_count),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_read_value),
        .o_flags (out_flags),
        .o_count (o_count)
    );

    assign o_found  = out_flags.found;
    assign o_status = out_flags.status;

endmodule

FILE: hw/rtl/ilte_checker.sv
// ----------------------------------------------------------------------------
// ilte_checker
// Port-level checks on the result channel of the indexed list table engine.
// ----------------------------------------------------------------------------
module ilte_checker #(
    parameter int DEPTH      = ilte_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ilte_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [DATA_WIDTH-1:0] o_read_value,
    input  logic                        o_found,
    input  logic [$clog2(DEPTH+1)-1:0]  o_count,
    input  ilte_pkg::t_status           o_status
);

    import ilte_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    a_reset_drops_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_read_value) && $stable(o_count) && $stable(o_status))
        else $error("stalled result changed");

    a_fail_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_read_value == '0 && !o_found)
        else $error("failed request carries data or found");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> o_status == ST_OK && o_read_value == '0)
        else $error("found with bad status or data");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_count <= CW'(DEPTH))
        else $error("count above depth");

endmodule

bind indexed_list_table_engine ilte_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_ilte_checker (.*);
